### src/fdc_pkg.sv
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types, constants and the byte-wide CRC-16-CCITT step of the frame
// deframer.
// ----------------------------------------------------------------------------
package fdc_pkg;

   localparam int CNT_W     = 17;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DW    = 16;
   localparam int CALL_W    = 64;

   localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;
   localparam logic [15:0]      CRC_INIT  = 16'hFFFF;
   localparam logic [15:0]      CRC_POLY  = 16'h1021;
   localparam logic [15:0]      CRC_TOP   = 16'h8000;

   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_TYPE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_TYPE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT    = 2'd3;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_MAGIC     = 3'd2,
      ST_TYPE      = 3'd3,
      ST_LENGTH    = 3'd4,
      ST_TRUNCATED = 3'd5,
      ST_CRC       = 3'd6
   } status_type;

   // one queued word: an optional payload byte and an optional frame report
   typedef struct packed {
      logic              has_pay;
      logic [7:0]        pay_byte;
      logic              has_rep;
      logic [7:0]        frame_type;
      logic [7:0]        frame_flags;
      logic [7:0]        sequence_number;
      logic [CALL_W-1:0] source_call;
      logic [CALL_W-1:0] dest_call;
      logic [15:0]       payload_length;
      status_type        status;
   } entry_type;

   typedef struct packed {
      logic              kind;
      logic [7:0]        payload_byte;
      logic [7:0]        frame_type;
      logic [7:0]        frame_flags;
      logic [7:0]        sequence_number;
      logic [CALL_W-1:0] source_call;
      logic [CALL_W-1:0] dest_call;
      logic [15:0]       payload_length;
      status_type        status;
   } result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

### src/fdc_req_if.sv
// ----------------------------------------------------------------------------
// fdc_req_if
// Input byte channel: valid/ready with one received byte and its last flag.
// ----------------------------------------------------------------------------
interface fdc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_byte;

   modport source(output valid, output byte_in, output last_byte, input ready);
   modport sink(input valid, input byte_in, input last_byte, output ready);
endinterface

### src/fdc_rsp_if.sv
// ----------------------------------------------------------------------------
// fdc_rsp_if
// Result channel: valid/ready with a payload byte or a frame report.
// ----------------------------------------------------------------------------
interface fdc_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  payload_byte;
   logic [7:0]  frame_type;
   logic [7:0]  frame_flags;
   logic [7:0]  sequence_number;
   logic [63:0] source_call;
   logic [63:0] dest_call;
   logic [15:0] payload_length;
   logic [2:0]  status;

   modport source(output valid, output kind, output payload_byte, output frame_type,
                  output frame_flags, output sequence_number, output source_call,
                  output dest_call, output payload_length, output status, input ready);
   modport sink(input valid, input kind, input payload_byte, input frame_type,
                input frame_flags, input sequence_number, input source_call,
                input dest_call, input payload_length, input status, output ready);
endinterface

### src/fdc_front.sv
// ----------------------------------------------------------------------------
// fdc_front
// Byte parser: tracks position, captures the header, runs the CRC, holds the
// control registers and queues payload bytes and end-of-buffer reports.
// ----------------------------------------------------------------------------
module fdc_front #(
   parameter int CALL_BYTES  = 8,
   parameter int PAYLOAD_MAX = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   fdc_req_if.sink                        req,
   input  logic                           csr_we,
   input  logic [fdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fdc_pkg::CSR_DW-1:0]     csr_wdata,
   output logic                           push_valid,
   output fdc_pkg::entry_type             push_entry,
   input  logic                           push_ready
);

   localparam int HDR_LEN  = 4 + 2 * CALL_BYTES + 2;
   localparam int CNT_W    = fdc_pkg::CNT_W;
   localparam logic [CNT_W-1:0] HDR_LEN_C = CNT_W'(HDR_LEN);

   logic [7:0]       magic_ff, magic_in;
   logic [7:0]       low_type_ff, low_type_in;
   logic [7:0]       high_type_ff, high_type_in;
   logic [15:0]      limit_ff, limit_in;

   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_nx;
   logic [15:0]      crc_ff, crc_in, crc_nx;
   logic [15:0]      frozen_ff, frozen_in, frozen_nx;
   logic [15:0]      rx_crc_ff, rx_crc_in, rx_crc_nx;
   logic             magic_ok_ff, magic_ok_in, magic_ok_nx;
   logic [7:0]       hdr_ff [HDR_LEN];
   logic [7:0]       hdr_in [HDR_LEN];
   logic [7:0]       hdr_nx [HDR_LEN];

   logic             accept, clear, in_hdr, in_pay;
   logic [15:0]      len_cur, len_nx;
   logic [CNT_W-1:0] pay_end, need_cnt;
   logic [7:0]       t_nx;
   logic [63:0]      src_nx, dst_nx;
   fdc_pkg::status_type status_nx;

   assign req.ready = push_ready;
   assign accept    = req.valid & push_ready;
   assign clear     = accept & req.last_byte;

   always_comb begin
      magic_in     = magic_ff;
      low_type_in  = low_type_ff;
      high_type_in = high_type_ff;
      limit_in     = limit_ff;
      if (csr_we) begin
         case (csr_index)
            fdc_pkg::CSR_MAGIC:     magic_in     = csr_wdata[7:0];
            fdc_pkg::CSR_LOW_TYPE:  low_type_in  = csr_wdata[7:0];
            fdc_pkg::CSR_HIGH_TYPE: high_type_in = csr_wdata[7:0];
            fdc_pkg::CSR_LIMIT:     limit_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      len_cur = {hdr_ff[HDR_LEN-2], hdr_ff[HDR_LEN-1]};
      pay_end = HDR_LEN_C + {1'b0, len_cur};
      in_hdr  = cnt_ff < HDR_LEN_C;
      in_pay  = !in_hdr && (cnt_ff < pay_end);

      for (int i = 0; i < HDR_LEN; i++) begin
         hdr_nx[i] = (accept && cnt_ff == CNT_W'(i)) ? req.byte_in : hdr_ff[i];
         hdr_in[i] = clear ? 8'h00 : hdr_nx[i];
      end

      magic_ok_nx = (accept && cnt_ff == '0) ? (req.byte_in == magic_ff) : magic_ok_ff;
      crc_nx      = (accept && (in_hdr || in_pay)) ?
                    fdc_pkg::crc_byte(crc_ff, req.byte_in) : crc_ff;
      frozen_nx   = frozen_ff;
      rx_crc_nx   = rx_crc_ff;
      if (accept && !in_hdr && cnt_ff == pay_end) begin
         frozen_nx = crc_ff;
         rx_crc_nx = {req.byte_in, 8'h00};
      end else if (accept && !in_hdr && cnt_ff == pay_end + CNT_W'(1)) begin
         rx_crc_nx = {rx_crc_ff[15:8], req.byte_in};
      end
      if (!accept) begin
         cnt_nx = cnt_ff;
      end else if (cnt_ff == fdc_pkg::COUNT_MAX) begin
         cnt_nx = cnt_ff;
      end else begin
         cnt_nx = cnt_ff + CNT_W'(1);
      end

      cnt_in      = clear ? '0 : cnt_nx;
      crc_in      = clear ? fdc_pkg::CRC_INIT : crc_nx;
      frozen_in   = clear ? 16'h0000 : frozen_nx;
      rx_crc_in   = clear ? 16'h0000 : rx_crc_nx;
      magic_ok_in = clear ? 1'b0 : magic_ok_nx;
   end

   // report fields, taken from the state including the current byte
   always_comb begin
      t_nx     = hdr_nx[1];
      len_nx   = {hdr_nx[HDR_LEN-2], hdr_nx[HDR_LEN-1]};
      need_cnt = HDR_LEN_C + {1'b0, len_nx} + CNT_W'(2);
      src_nx   = '0;
      dst_nx   = '0;
      for (int i = 0; i < CALL_BYTES; i++) begin
         src_nx[(CALL_BYTES-1-i)*8 +: 8] = hdr_nx[4+i];
         dst_nx[(CALL_BYTES-1-i)*8 +: 8] = hdr_nx[4+CALL_BYTES+i];
      end
      if (cnt_nx < HDR_LEN_C + CNT_W'(2)) begin
         status_nx = fdc_pkg::ST_SHORT;
      end else if (!magic_ok_nx) begin
         status_nx = fdc_pkg::ST_MAGIC;
      end else if (t_nx < low_type_ff || t_nx > high_type_ff) begin
         status_nx = fdc_pkg::ST_TYPE;
      end else if (len_nx > limit_ff) begin
         status_nx = fdc_pkg::ST_LENGTH;
      end else if (cnt_nx < need_cnt) begin
         status_nx = fdc_pkg::ST_TRUNCATED;
      end else if (rx_crc_nx != frozen_nx) begin
         status_nx = fdc_pkg::ST_CRC;
      end else begin
         status_nx = fdc_pkg::ST_OK;
      end
   end

   always_comb begin
      push_valid                 = accept && (in_pay || req.last_byte);
      push_entry.has_pay         = in_pay;
      push_entry.pay_byte        = req.byte_in;
      push_entry.has_rep         = req.last_byte;
      push_entry.frame_type      = t_nx;
      push_entry.frame_flags     = hdr_nx[2];
      push_entry.sequence_number = hdr_nx[3];
      push_entry.source_call     = src_nx;
      push_entry.dest_call       = dst_nx;
      push_entry.payload_length  = len_nx;
      push_entry.status          = status_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff     <= 8'h00;
         low_type_ff  <= 8'h00;
         high_type_ff <= 8'd10;
         limit_ff     <= 16'(PAYLOAD_MAX);
         cnt_ff       <= '0;
         crc_ff       <= fdc_pkg::CRC_INIT;
         frozen_ff    <= 16'h0000;
         rx_crc_ff    <= 16'h0000;
         magic_ok_ff  <= 1'b0;
         for (int i = 0; i < HDR_LEN; i++) begin
            hdr_ff[i] <= 8'h00;
         end
      end else begin
         magic_ff     <= magic_in;
         low_type_ff  <= low_type_in;
         high_type_ff <= high_type_in;
         limit_ff     <= limit_in;
         cnt_ff       <= cnt_in;
         crc_ff       <= crc_in;
         frozen_ff    <= frozen_in;
         rx_crc_ff    <= rx_crc_in;
         magic_ok_ff  <= magic_ok_in;
         for (int i = 0; i < HDR_LEN; i++) begin
            hdr_ff[i] <= hdr_in[i];
         end
      end
   end

endmodule

### src/fdc_queue.sv
// ----------------------------------------------------------------------------
// fdc_queue
// Two-word queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module fdc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  fdc_pkg::entry_type push_entry,
   output logic               push_ready,
   output logic               head_valid,
   output fdc_pkg::entry_type head_entry,
   input  logic               pop
);

   fdc_pkg::entry_type mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign push_ready = cnt_ff != 2'd2;
   assign head_valid = cnt_ff != 2'd0;
   assign head_entry = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

### src/fdc_back.sv
// ----------------------------------------------------------------------------
// fdc_back
// Result stage: turns each queued word into a payload result, a report, or
// both in that order, through one output register.
// ----------------------------------------------------------------------------
module fdc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  fdc_pkg::entry_type head_entry,
   output logic               pop,
   fdc_rsp_if.source          rsp
);

   logic                 valid_ff, valid_in;
   logic                 phase_ff, phase_in;
   fdc_pkg::result_type  res_ff, res_in;
   logic                 load, first_pay;

   always_comb begin
      load      = head_valid && (!valid_ff || rsp.ready);
      first_pay = head_entry.has_pay && !phase_ff;
      pop       = load && !(first_pay && head_entry.has_rep);
      phase_in  = load ? (first_pay && head_entry.has_rep) : phase_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end

      res_in = '0;
      if (first_pay) begin
         res_in.kind         = 1'b0;
         res_in.payload_byte = head_entry.pay_byte;
         res_in.status       = fdc_pkg::ST_OK;
      end else begin
         res_in.kind            = 1'b1;
         res_in.frame_type      = head_entry.frame_type;
         res_in.frame_flags     = head_entry.frame_flags;
         res_in.sequence_number = head_entry.sequence_number;
         res_in.source_call     = head_entry.source_call;
         res_in.dest_call       = head_entry.dest_call;
         res_in.payload_length  = head_entry.payload_length;
         res_in.status          = head_entry.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign rsp.valid           = valid_ff;
   assign rsp.kind            = res_ff.kind;
   assign rsp.payload_byte    = res_ff.payload_byte;
   assign rsp.frame_type      = res_ff.frame_type;
   assign rsp.frame_flags     = res_ff.frame_flags;
   assign rsp.sequence_number = res_ff.sequence_number;
   assign rsp.source_call     = res_ff.source_call;
   assign rsp.dest_call       = res_ff.dest_call;
   assign rsp.payload_length  = res_ff.payload_length;
   assign rsp.status          = res_ff.status;

endmodule

### src/frame_deframer_crc16_check_top.sv
// ----------------------------------------------------------------------------
// frame_deframer_crc16_check_top
// Framed packet parser with CRC-16-CCITT check.
// ----------------------------------------------------------------------------
// Takes one byte per cycle: the parser updates the CRC a whole byte at a time,
// so req_chan.ready stays high as long as the two-word queue has room. Each
// payload byte comes out as one word; the byte marked last gives a frame
// report, and if it is also a payload byte, the payload word comes first and
// the report follows it, so that byte occupies the single output register
// twice. From accept, a word passes through the two-word queue and then the
// output register to rsp_chan.valid. No clearing pass after reset;
// configuration writes take effect on the next cycle.
module frame_deframer_crc16_check_top #(
   parameter int CALL_BYTES  = 8,
   parameter int PAYLOAD_MAX = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   fdc_req_if.sink                        req_chan,
   fdc_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [fdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fdc_pkg::CSR_DW-1:0]     csr_wdata
);

   logic               push_valid, push_ready, head_valid, pop;
   fdc_pkg::entry_type push_entry, head_entry;

   fdc_front #(
      .CALL_BYTES  (CALL_BYTES),
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   fdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   fdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

### src/fdc_check.sv
// ----------------------------------------------------------------------------
// fdc_check
// Port-level checks on the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fdc_check (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [7:0]  rsp_payload_byte,
   input logic [15:0] rsp_payload_length,
   input logic [2:0]  rsp_status
);

   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("outputs not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind)
                                     && $stable(rsp_payload_byte)
                                     && $stable(rsp_status)))
      else $error("stalled result word changed");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_kind) |->
         (rsp_status == fdc_pkg::ST_OK && rsp_payload_length == 16'h0000))
      else $error("payload word carries report fields");

   a_report_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind) |-> (rsp_payload_byte == 8'h00))
      else $error("report word carries a payload byte");

endmodule

bind frame_deframer_crc16_check_top fdc_check u_fdc_check (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_kind           (rsp_chan.kind),
   .rsp_payload_byte   (rsp_chan.payload_byte),
   .rsp_payload_length (rsp_chan.payload_length),
   .rsp_status         (rsp_chan.status)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives framed byte buffers into the CRC-16 deframer and checks every
// payload word and frame report against a scoreboard that tracks the parser
// state. Mixes good frames with corrupted ones, runs several register
// settings and varies back-pressure on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CALL_LEN       = 8;
   localparam int HEADER_BYTES   = 4 + 2 * CALL_LEN + 2;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTING_BUDGET = 90;

   logic                          clock;
   logic                          reset;
   logic                          csr_we;
   logic [fdc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [fdc_pkg::CSR_DW-1:0]    csr_wdata;

   fdc_req_if req_if();
   fdc_rsp_if rsp_if();

   frame_deframer_crc16_check_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // bit-serial CCITT update, MSB first
   function automatic logic [15:0] ccitt_update(logic [15:0] acc, logic [7:0] data);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = acc[15] ^ data[i];
         acc = {acc[14:0], 1'b0};
         if (fb) begin
            acc = acc ^ fdc_pkg::CRC_POLY;
         end
      end
      return acc;
   endfunction

   class deframe_scoreboard;
      logic [7:0]                magic_cfg;
      logic [7:0]                low_type_cfg;
      logic [7:0]                high_type_cfg;
      logic [15:0]               limit_cfg;
      logic [fdc_pkg::CNT_W-1:0] pos_count;
      logic [15:0]               crc_acc;
      logic [15:0]               crc_at_end;
      logic [15:0]               crc_rx;
      logic [7:0]                hdr[HEADER_BYTES];
      bit                        magic_seen;
      fdc_pkg::result_type       due_words[$];
      int                        errors;
      int                        reports;
      int                        payload_words;
      int                        status_hits[7];

      function new();
         magic_cfg     = 8'd0;
         low_type_cfg  = 8'd0;
         high_type_cfg = 8'd10;
         limit_cfg     = 16'd1024;
         errors        = 0;
         reports       = 0;
         payload_words = 0;
         foreach (status_hits[i]) status_hits[i] = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         pos_count  = '0;
         crc_acc    = fdc_pkg::CRC_INIT;
         crc_at_end = 16'h0000;
         crc_rx     = 16'h0000;
         magic_seen = 1'b0;
         foreach (hdr[i]) hdr[i] = 8'h00;
      endfunction

      function void set_register(logic [fdc_pkg::CSR_IDX_W-1:0] idx,
                                 logic [fdc_pkg::CSR_DW-1:0] val);
         case (idx)
            fdc_pkg::CSR_MAGIC:     magic_cfg     = val[7:0];
            fdc_pkg::CSR_LOW_TYPE:  low_type_cfg  = val[7:0];
            fdc_pkg::CSR_HIGH_TYPE: high_type_cfg = val[7:0];
            fdc_pkg::CSR_LIMIT:     limit_cfg     = val;
            default: ;
         endcase
      endfunction

      // advance the parser by one accepted byte and queue the words it yields
      function void absorb_byte(logic [7:0] b, logic last);
         int                  pos;
         int                  len;
         int                  cnt;
         fdc_pkg::result_type w;
         pos = int'(pos_count);
         len = int'({hdr[HEADER_BYTES-2], hdr[HEADER_BYTES-1]});
         if (pos < HEADER_BYTES) begin
            hdr[pos] = b;
            if (pos == 0) begin
               magic_seen = (b == magic_cfg);
            end
            crc_acc = ccitt_update(crc_acc, b);
         end else if (pos < HEADER_BYTES + len) begin
            crc_acc = ccitt_update(crc_acc, b);
            w = '0;
            w.kind = 1'b0;
            w.payload_byte = b;
            due_words = {due_words, w};
         end else if (pos == HEADER_BYTES + len) begin
            crc_at_end = crc_acc;
            crc_rx     = {b, 8'h00};
         end else if (pos == HEADER_BYTES + len + 1) begin
            crc_rx[7:0] = b;
         end
         if (pos_count != fdc_pkg::COUNT_MAX) begin
            pos_count = pos_count + 1'b1;
         end
         if (last) begin
            cnt = int'(pos_count);
            len = int'({hdr[HEADER_BYTES-2], hdr[HEADER_BYTES-1]});
            w = '0;
            w.kind = 1'b1;
            w.frame_type = hdr[1];
            w.frame_flags = hdr[2];
            w.sequence_number = hdr[3];
            for (int i = 0; i < CALL_LEN; i++) begin
               w.source_call = {w.source_call[fdc_pkg::CALL_W-9:0], hdr[4+i]};
               w.dest_call   = {w.dest_call[fdc_pkg::CALL_W-9:0], hdr[4+CALL_LEN+i]};
            end
            w.payload_length = 16'(len);
            if (cnt < HEADER_BYTES + 2) begin
               w.status = fdc_pkg::ST_SHORT;
            end else if (!magic_seen) begin
               w.status = fdc_pkg::ST_MAGIC;
            end else if (hdr[1] < low_type_cfg || hdr[1] > high_type_cfg) begin
               w.status = fdc_pkg::ST_TYPE;
            end else if (len > int'(limit_cfg)) begin
               w.status = fdc_pkg::ST_LENGTH;
            end else if (cnt < HEADER_BYTES + len + 2) begin
               w.status = fdc_pkg::ST_TRUNCATED;
            end else if (crc_rx != crc_at_end) begin
               w.status = fdc_pkg::ST_CRC;
            end else begin
               w.status = fdc_pkg::ST_OK;
            end
            due_words = {due_words, w};
            clear_frame();
         end
      endfunction

      task flag_mismatch(string field, logic [63:0] got_v, logic [63:0] want_v);
         errors++;
         $display("mismatch in %s: got %h, expected %h", field, got_v, want_v);
      endtask

      task match_word(fdc_pkg::result_type got);
         fdc_pkg::result_type want;
         if (due_words.size() == 0) begin
            flag_mismatch("word with nothing due", 64'(got.kind), 64'd0);
            return;
         end
         want = due_words.pop_front();
         if (got.kind !== want.kind)
            flag_mismatch("kind", 64'(got.kind), 64'(want.kind));
         if (got.payload_byte !== want.payload_byte)
            flag_mismatch("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
         if (got.frame_type !== want.frame_type)
            flag_mismatch("frame_type", 64'(got.frame_type), 64'(want.frame_type));
         if (got.frame_flags !== want.frame_flags)
            flag_mismatch("frame_flags", 64'(got.frame_flags), 64'(want.frame_flags));
         if (got.sequence_number !== want.sequence_number)
            flag_mismatch("sequence_number", 64'(got.sequence_number),
                          64'(want.sequence_number));
         if (got.source_call !== want.source_call)
            flag_mismatch("source_call", got.source_call, want.source_call);
         if (got.dest_call !== want.dest_call)
            flag_mismatch("dest_call", got.dest_call, want.dest_call);
         if (got.payload_length !== want.payload_length)
            flag_mismatch("payload_length", 64'(got.payload_length), 64'(want.payload_length));
         if (got.status !== want.status)
            flag_mismatch("status", 64'(got.status), 64'(want.status));
         if (want.kind) begin
            reports++;
            status_hits[int'(want.status)]++;
         end else begin
            payload_words++;
         end
      endtask
   endclass

   deframe_scoreboard sb;
   logic [7:0]        frame_bytes[$];
   int                send_idle_pct;
   int                recv_stall_pct;
   int                rsp_hold_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: take words, apply random stalls and the long hold-off
   initial begin
      fdc_pkg::result_type got;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.kind            = rsp_if.kind;
            got.payload_byte    = rsp_if.payload_byte;
            got.frame_type      = rsp_if.frame_type;
            got.frame_flags     = rsp_if.frame_flags;
            got.sequence_number = rsp_if.sequence_number;
            got.source_call     = rsp_if.source_call;
            got.dest_call       = rsp_if.dest_call;
            got.payload_length  = rsp_if.payload_length;
            got.status          = fdc_pkg::status_type'(rsp_if.status);
            sb.match_word(got);
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
   end

   task automatic send_byte(logic [7:0] b, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.byte_in   <= b;
      req_if.last_byte <= last;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      sb.absorb_byte(b, last);
   endtask

   task automatic send_buffer(int trailing);
      foreach (frame_bytes[i]) begin
         send_byte(frame_bytes[i], trailing == 0 && i == frame_bytes.size() - 1);
      end
      for (int j = 0; j < trailing; j++) begin
         send_byte(8'($urandom), j == trailing - 1);
      end
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (sb.due_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [fdc_pkg::CSR_IDX_W-1:0] idx,
                                 logic [fdc_pkg::CSR_DW-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_register(idx, val);
   endtask

   // upper bits of the 8-bit registers carry junk that must be dropped
   task automatic apply_settings(logic [7:0] mg, logic [7:0] lo, logic [7:0] hi,
                                 logic [15:0] lim);
      write_register(fdc_pkg::CSR_MAGIC, {8'($urandom), mg});
      write_register(fdc_pkg::CSR_LOW_TYPE, {8'($urandom), lo});
      write_register(fdc_pkg::CSR_HIGH_TYPE, {8'($urandom), hi});
      write_register(fdc_pkg::CSR_LIMIT, lim);
      csr_we <= 1'b0;
   endtask

   function automatic void add_byte(logic [7:0] b);
      frame_bytes = {frame_bytes, b};
   endfunction

   function automatic void build_frame(logic [7:0] mg, logic [7:0] ty, int len, int pay_count);
      frame_bytes.delete();
      add_byte(mg);
      add_byte(ty);
      add_byte(8'($urandom));
      add_byte(8'($urandom));
      repeat (2 * CALL_LEN) begin
         add_byte(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom));
      end
      add_byte(8'(len >> 8));
      add_byte(8'(len));
      repeat (pay_count) add_byte(8'($urandom));
   endfunction

   function automatic void append_crc();
      logic [15:0] acc;
      acc = fdc_pkg::CRC_INIT;
      foreach (frame_bytes[i]) acc = ccitt_update(acc, frame_bytes[i]);
      add_byte(acc[15:8]);
      add_byte(acc[7:0]);
   endfunction

   function automatic logic [7:0] legal_type();
      if (sb.low_type_cfg <= sb.high_type_cfg) begin
         return 8'($urandom_range(sb.high_type_cfg, sb.low_type_cfg));
      end
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] illegal_type();
      if (sb.low_type_cfg > sb.high_type_cfg) begin
         return 8'($urandom);
      end else if (sb.low_type_cfg > 0 && (sb.high_type_cfg == 8'hFF || $urandom_range(1))) begin
         return 8'($urandom_range(sb.low_type_cfg - 1, 0));
      end else if (sb.high_type_cfg < 8'hFF) begin
         return 8'($urandom_range(255, sb.high_type_cfg + 1));
      end
      return 8'($urandom);
   endfunction

   function automatic int legal_length();
      int cap;
      cap = (sb.limit_cfg < 10) ? int'(sb.limit_cfg) : 10;
      if ($urandom_range(9) == 0) begin
         cap = (sb.limit_cfg < 200) ? int'(sb.limit_cfg) : 200;
      end
      return $urandom_range(cap, 0);
   endfunction

   // some well-formed frames, most broken in one way each
   task automatic random_buffers(int budget);
      int         sent;
      int         pick;
      int         lenv;
      int         keep;
      int         spot;
      int         trailing;
      logic [7:0] mg;
      logic [7:0] ty;
      sent = 0;
      while (sent < budget) begin
         pick     = $urandom_range(9);
         mg       = sb.magic_cfg;
         ty       = legal_type();
         lenv     = legal_length();
         trailing = 0;
         case (pick)
            0: mg = mg ^ 8'($urandom_range(255, 1));
            1: ty = illegal_type();
            2: begin
               if (sb.limit_cfg != 16'hFFFF) begin
                  lenv = $urandom_range(65535, int'(sb.limit_cfg) + 1);
               end
            end
            default: ;
         endcase
         build_frame(mg, ty, lenv, (pick == 2) ? $urandom_range(6) : lenv);
         append_crc();
         case (pick)
            3: begin
               frame_bytes.delete();
               repeat ($urandom_range(40, 1)) add_byte(8'($urandom));
            end
            4: begin
               keep = $urandom_range(HEADER_BYTES + 1, 1);
               while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
            end
            5: begin
               keep = $urandom_range(frame_bytes.size() - 1, HEADER_BYTES);
               while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
            end
            6: begin
               spot = frame_bytes.size() - 1 - $urandom_range(1);
               frame_bytes[spot] = frame_bytes[spot] ^ 8'(1 << $urandom_range(7));
            end
            9: trailing = $urandom_range(6, 1);
            default: ;
         endcase
         send_buffer(trailing);
         sent += frame_bytes.size();
      end
   endtask

   initial begin
      sb               = new();
      send_idle_pct    = 20;
      recv_stall_pct   = 83;
      rsp_hold_cycles  = 0;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.byte_in   <= 8'h00;
      req_if.last_byte <= 1'b0;
      csr_we           <= 1'b0;
      csr_index        <= fdc_pkg::CSR_MAGIC;
      csr_wdata        <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one-byte buffer, then a minimal good frame at reset settings
      frame_bytes.delete();
      add_byte(8'hFF);
      send_buffer(0);
      build_frame(8'h00, 8'd10, 0, 0);
      frame_bytes[2] = 8'hFF;
      frame_bytes[3] = 8'h00;
      for (int i = 0; i < CALL_LEN; i++) begin
         frame_bytes[4+i]          = 8'hFF;
         frame_bytes[4+CALL_LEN+i] = 8'h00;
      end
      append_crc();
      send_buffer(0);
      drain_results();

      apply_settings(8'h7E, 8'd0, 8'd10, 16'd1024);
      random_buffers(SETTING_BUDGET);
      drain_results();
      apply_settings(8'hFF, 8'hFF, 8'hFF, 16'd0);
      random_buffers(SETTING_BUDGET);
      drain_results();

      send_idle_pct  = 83;
      recv_stall_pct = 20;
      apply_settings(8'h00, 8'd200, 8'd3, 16'hFFFF);
      random_buffers(SETTING_BUDGET);
      drain_results();
      apply_settings(8'($urandom), 8'd1, 8'd254, 16'd20);
      random_buffers(SETTING_BUDGET);
      drain_results();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      apply_settings(8'hA5, 8'h00, 8'hFF, 16'd300);
      rsp_hold_cycles = 60;
      random_buffers(SETTING_BUDGET);
      // good frame followed by a few ignored bytes
      build_frame(sb.magic_cfg, legal_type(), 0, 0);
      append_crc();
      send_buffer($urandom_range(8, 1));
      drain_results();
      repeat (8) @(posedge clock);

      $display("covered %0d frame reports and %0d payload words over six register settings",
               sb.reports, sb.payload_words);
      $display("statuses: ok %0d short %0d magic %0d type %0d length %0d trunc %0d crc %0d",
               sb.status_hits[0], sb.status_hits[1], sb.status_hits[2], sb.status_hits[3],
               sb.status_hits[4], sb.status_hits[5], sb.status_hits[6]);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
